// ===== rtl/rscb_pkg.sv =====
package rscb_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SumW    = 18;
  localparam int unsigned SpanW   = 11;
  localparam int unsigned ModW    = 18;
  localparam int unsigned MinDistW = 20;
  localparam int unsigned SeenW   = 21;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned OutDataW = 24;

  // Default for the window store depth
  localparam int unsigned MaxSpanDefault = 1024;

  // Queue between the front and back parts
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Divider step counter
  localparam int unsigned DivCntW = $clog2(SumW);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgWindowSpan  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgModulus     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinDistance = 2'd2;

  // Register reset values
  localparam logic [SpanW-1:0]    SpanReset    = 11'd256;
  localparam logic [ModW-1:0]     ModulusReset = 18'd8192;
  localparam logic [MinDistW-1:0] MinDistReset = 20'd8192;

  typedef struct packed {
    logic [SpanW-1:0]    window_span;
    logic [ModW-1:0]     modulus;
    logic [MinDistW-1:0] min_distance;
  } cfg_t;

  // One updated sum on its way to the modulo check
  typedef struct packed {
    logic            cut_ok;
    logic [SumW-1:0] sum;
  } q_item_t;

  typedef enum logic {
    F_IDLE,
    F_UPDATE
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIVIDE,
    B_OUTPUT
  } back_state_e;

endpackage

// ===== rtl/rscb_front.sv =====
module rscb_front #(
  parameter int unsigned MAX_SPAN = rscb_pkg::MaxSpanDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rscb_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rscb_pkg::ByteW-1:0]   in_byte_i,
  input  logic                         in_restart_i,
  input  logic                         q_ready_i,
  output logic                         q_push_o,
  output rscb_pkg::q_item_t            q_item_o
);
  import rscb_pkg::*;

  localparam int unsigned PosW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
  localparam int unsigned CntW = PosW + 1;

  front_state_e state_q, state_d;

  logic [ByteW-1:0] window_mem [MAX_SPAN];
  logic [ByteW-1:0] old_byte_q;
  logic [ByteW-1:0] byte_q;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [SeenW-1:0] seen_q, seen_d;
  logic             full_q, full_d;
  logic             may_cut_q, may_cut_d;

  logic             accept;
  logic [PosW-1:0]  rd_addr;
  logic [31:0]      span_wide;
  logic [CntW-1:0]  span_eff;
  logic [CntW-1:0]  pos_inc;
  logic [ByteW-1:0] leaving;

  assign accept  = in_valid_i && in_ready_o;
  assign rd_addr = in_restart_i ? '0 : pos_q;

  // Span of 0 acts as 1, above the store depth acts as the depth
  always_comb begin
    if (cfg_i.window_span == '0) begin
      span_wide = 32'd1;
    end else if (32'(cfg_i.window_span) > 32'(MAX_SPAN)) begin
      span_wide = 32'(MAX_SPAN);
    end else begin
      span_wide = 32'(cfg_i.window_span);
    end
  end
  assign span_eff = span_wide[CntW-1:0];

  assign pos_inc = {1'b0, pos_q} + CntW'(1);
  assign leaving = full_q ? old_byte_q : '0;

  always_comb begin
    pos_d     = pos_q;
    full_d    = full_q;
    sum_d     = sum_q - SumW'(leaving) + SumW'(byte_q);
    seen_d    = seen_q;
    may_cut_d = may_cut_q;
    if (pos_inc >= span_eff) begin
      pos_d  = '0;
      full_d = 1'b1;
    end else begin
      pos_d = pos_inc[PosW-1:0];
    end
    if (!may_cut_q) begin
      if (seen_q >= SeenW'(cfg_i.min_distance)) begin
        may_cut_d = 1'b1;
      end
      seen_d = seen_q + SeenW'(1);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_UPDATE;
        end
      end
      F_UPDATE: begin
        state_d = F_IDLE;
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    q_push_o   = 1'b0;
    case (state_q)
      F_IDLE: begin
        in_ready_o = q_ready_i;
      end
      F_UPDATE: begin
        q_push_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign q_item_o.cut_ok = may_cut_d;
  assign q_item_o.sum    = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      pos_q     <= '0;
      sum_q     <= '0;
      seen_q    <= '0;
      full_q    <= 1'b0;
      may_cut_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && in_restart_i) begin
        pos_q     <= '0;
        sum_q     <= '0;
        seen_q    <= '0;
        full_q    <= 1'b0;
        may_cut_q <= 1'b0;
      end else if (state_q == F_UPDATE) begin
        pos_q     <= pos_d;
        sum_q     <= sum_d;
        seen_q    <= seen_d;
        full_q    <= full_d;
        may_cut_q <= may_cut_d;
      end
    end
  end

  // Window store: read the outgoing byte on accept, overwrite it in the F_UPDATE state
  always_ff @(posedge clk_i) begin
    if (accept) begin
      old_byte_q <= window_mem[rd_addr];
      byte_q     <= in_byte_i;
    end
    if (state_q == F_UPDATE) begin
      window_mem[pos_q] <= byte_q;
    end
  end

endmodule

// ===== rtl/rscb_fifo.sv =====
module rscb_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rscb_pkg::q_item_t item_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_i,
  output rscb_pkg::q_item_t item_o
);
  import rscb_pkg::*;

  q_item_t               slots_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  count_q;
  logic                  do_push, do_pop;

  assign ready_o = count_q != QueueCntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/rscb_back.sv =====
module rscb_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [rscb_pkg::ModW-1:0]  modulus_i,
  input  logic                       q_valid_i,
  output logic                       q_pop_o,
  input  rscb_pkg::q_item_t          q_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       out_boundary_o,
  output logic [rscb_pkg::SumW-1:0]  out_sum_o
);
  import rscb_pkg::*;

  back_state_e state_q, state_d;

  logic [DivCntW-1:0] step_q;
  logic [SumW-1:0]    dvd_q;
  logic [ModW-1:0]    rem_q;
  logic [SumW-1:0]    sum_q;
  logic               cut_ok_q;

  logic [ModW:0]      trial;
  logic [ModW:0]      trial_sub;
  logic [ModW-1:0]    rem_d;
  logic               last_step;

  // Restoring division, one quotient bit per cycle, remainder only
  assign trial     = {rem_q, dvd_q[SumW-1]};
  assign trial_sub = trial - {1'b0, modulus_i};
  assign rem_d     = (trial >= {1'b0, modulus_i}) ? trial_sub[ModW-1:0] : trial[ModW-1:0];
  assign last_step = step_q == DivCntW'(SumW - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          state_d = B_DIVIDE;
        end
      end
      B_DIVIDE: begin
        if (last_step) begin
          state_d = B_OUTPUT;
        end
      end
      B_OUTPUT: begin
        if (out_ready_i) begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop_o     = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      B_IDLE: begin
        q_pop_o = q_valid_i;
      end
      B_OUTPUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  assign out_boundary_o = cut_ok_q && (modulus_i != '0) && (rem_q == '0);
  assign out_sum_o      = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_IDLE) begin
        step_q <= '0;
      end else if (state_q == B_DIVIDE) begin
        step_q <= step_q + DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      dvd_q    <= q_item_i.sum;
      sum_q    <= q_item_i.sum;
      cut_ok_q <= q_item_i.cut_ok;
      rem_q    <= '0;
    end else if (state_q == B_DIVIDE) begin
      dvd_q <= {dvd_q[SumW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

endmodule

// ===== rtl/rolling_sum_chunk_boundary_top.sv =====
// Channel    | Direction | Handshake                   | Payload
// s_axis     | in        | s_axis_tvalid/s_axis_tready | tdata: data_byte; tuser: restart
// m_axis     | out       | m_axis_tvalid/m_axis_tready | tdata: window_sum; tuser: boundary
// cfg        | in        | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// Each byte goes through the front part (window store read, then sum update and store
// write; no new byte is taken until the update is done) and then the back part, where
// an 18-step serial divider finds the remainder of the sum and sets the sustained rate.
// A two-entry queue lets the front take new bytes while the back is still dividing or
// its result waits on m_axis. Reset clears all control state and restores the register
// defaults; the window store has no reset and needs no clearing.
module rolling_sum_chunk_boundary_top #(
  parameter int unsigned MAX_SPAN = rscb_pkg::MaxSpanDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  input  logic                           s_axis_tuser,  // [0] restart
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rscb_pkg::OutDataW-1:0]  m_axis_tdata,  // [17:0] window_sum, rest zero
  output logic                           m_axis_tuser,  // [0] boundary
  // Configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rscb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rscb_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rscb_pkg::*;

  cfg_t    cfg_q;
  q_item_t push_item;
  q_item_t head_item;
  logic    q_push, q_ready, q_valid, q_pop;
  logic [SumW-1:0] out_sum;

  // Configuration is always taken; writes to an unused index are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_span  <= SpanReset;
      cfg_q.modulus      <= ModulusReset;
      cfg_q.min_distance <= MinDistReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgWindowSpan:  cfg_q.window_span  <= cfg_data_i[SpanW-1:0];
        CfgModulus:     cfg_q.modulus      <= cfg_data_i[ModW-1:0];
        CfgMinDistance: cfg_q.min_distance <= cfg_data_i[MinDistW-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Front part: window store, rolling sum and the cut permission.
  rscb_front #(
    .MAX_SPAN (MAX_SPAN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_restart_i (s_axis_tuser),
    .q_ready_i    (q_ready),
    .q_push_o     (q_push),
    .q_item_o     (push_item)
  );

  // Short queue so the front and back parts stall independently.
  rscb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (head_item)
  );

  // Back part: serial modulo check and the result register.
  rscb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .modulus_i      (cfg_q.modulus),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_item_i       (head_item),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_boundary_o (m_axis_tuser),
    .out_sum_o      (out_sum)
  );

  assign m_axis_tdata = {(OutDataW - SumW)'(0), out_sum};

endmodule
